/* hdl/hcbd_pkg.sv */
package hcbd_pkg;

    // Width of the chunk length counter.
    localparam int COUNT_BITS = 32;

    localparam int BYTE_BITS = 8;
    localparam int KIND_BITS = 2;

    // Unit step of the chunk length counter.
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    // Character codes used by the size line parser.
    localparam logic [BYTE_BITS-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_BITS-1:0] CHAR_LF = 8'h0A;

    // Number of bytes skipped after every chunk payload.
    localparam logic [1:0] SKIP_BYTES = 2'd2;

    // Result kinds.
    localparam logic [KIND_BITS-1:0] KIND_DATA  = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_END   = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_ERROR = 2'd2;

    // Parser modes.
    typedef enum logic [2:0] {
        MODE_DIGITS  = 3'd0,
        MODE_IGNORE  = 3'd1,
        MODE_GOT_CR  = 3'd2,
        MODE_PAYLOAD = 3'd3,
        MODE_SKIP    = 3'd4,
        MODE_DONE    = 3'd5
    } parse_mode_t;

    // Hex digit decoder result.
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [BYTE_BITS-1:0] c);
        hex_digit_t d;
        d.valid = 1'b0;
        d.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d.valid = 1'b1;
            d.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d.valid = 1'b1;
            d.value = 4'(c - 8'h61 + 8'd10);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d.valid = 1'b1;
            d.value = 4'(c - 8'h41 + 8'd10);
        end
        return d;
    endfunction

endpackage

/* hdl/http_chunked_body_decoder_top.sv */
// HTTP chunked body decoder. Raw body bytes enter on the s_ stream, one per
// transaction, and only payload bytes leave on the m_ stream (kind 0); a zero
// length chunk gives one end result (kind 1), and a size line with no hex
// digit or a length that overflows the 32-bit counter gives one error result
// (kind 2). After an end or an error all bytes are dropped until a byte
// arrives with body_start set, which restarts the parser on that byte. Size
// line, CR LF and trailing bytes produce no result. The block takes one byte
// per clock whenever the downstream side keeps m_tready high: each byte sits
// in an input register, the parser works out its next mode and counter from
// it, and the result lands in an output register, so a byte passes through
// the input register and then the output register on its way to the m_ stream.
module http_chunked_body_decoder_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic [0:0] s_tuser,   // [0] body_start
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser    // [1:0] kind
);

    // Input stage.
    logic                            in_valid_reg;
    logic [hcbd_pkg::BYTE_BITS-1:0]  in_byte_reg;
    logic                            in_start_reg;

    // Parser state.
    hcbd_pkg::parse_mode_t           mode_reg, mode_next;
    logic [hcbd_pkg::COUNT_BITS-1:0] count_reg, count_next;
    logic                            digit_seen_reg, digit_seen_next;
    logic [1:0]                      skip_reg, skip_next;

    // Output stage.
    logic                            out_valid_reg, out_valid_next;
    logic [hcbd_pkg::BYTE_BITS-1:0]  out_byte_reg, out_byte_next;
    logic [hcbd_pkg::KIND_BITS-1:0]  out_kind_reg, out_kind_next;

    // Effective state after an optional body restart.
    hcbd_pkg::parse_mode_t           cur_mode;
    logic [hcbd_pkg::COUNT_BITS-1:0] cur_count;
    logic                            cur_digit_seen;
    logic [1:0]                      cur_skip;
    hcbd_pkg::hex_digit_t            hex;
    logic                            advance;
    logic [1:0]                      skip_dec;

    // The staged byte moves on when the output register is free or drains.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_kind_reg;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser[0];
        end
    end

    // Parser step for the staged byte.
    always_comb
    begin
        if (in_start_reg)
        begin
            cur_mode       = hcbd_pkg::MODE_DIGITS;
            cur_count      = '0;
            cur_digit_seen = 1'b0;
            cur_skip       = '0;
        end
        else
        begin
            cur_mode       = mode_reg;
            cur_count      = count_reg;
            cur_digit_seen = digit_seen_reg;
            cur_skip       = skip_reg;
        end

        hex      = hcbd_pkg::hex_decode(in_byte_reg);
        skip_dec = (cur_skip != 2'd0) ? cur_skip - 2'd1 : cur_skip;

        mode_next       = cur_mode;
        count_next      = cur_count;
        digit_seen_next = cur_digit_seen;
        skip_next       = cur_skip;
        out_valid_next  = 1'b0;
        out_byte_next   = '0;
        out_kind_next   = hcbd_pkg::KIND_DATA;

        unique case (cur_mode)
            hcbd_pkg::MODE_DIGITS:
            begin
                if (hex.valid)
                begin
                    // A digit that would shift bits out of the counter is fatal.
                    if (cur_count[hcbd_pkg::COUNT_BITS-1 -: 4] != 4'd0)
                    begin
                        mode_next      = hcbd_pkg::MODE_DONE;
                        out_valid_next = 1'b1;
                        out_kind_next  = hcbd_pkg::KIND_ERROR;
                    end
                    else
                    begin
                        count_next      = {cur_count[hcbd_pkg::COUNT_BITS-5:0], hex.value};
                        digit_seen_next = 1'b1;
                    end
                end
                else if (in_byte_reg == hcbd_pkg::CHAR_CR)
                    mode_next = hcbd_pkg::MODE_GOT_CR;
                else
                    mode_next = hcbd_pkg::MODE_IGNORE;
            end
            hcbd_pkg::MODE_IGNORE:
            begin
                if (in_byte_reg == hcbd_pkg::CHAR_CR)
                    mode_next = hcbd_pkg::MODE_GOT_CR;
            end
            hcbd_pkg::MODE_GOT_CR:
            begin
                if (in_byte_reg == hcbd_pkg::CHAR_CR)
                    mode_next = hcbd_pkg::MODE_GOT_CR;
                else if (in_byte_reg != hcbd_pkg::CHAR_LF)
                    mode_next = hcbd_pkg::MODE_IGNORE;
                else if (!cur_digit_seen)
                begin
                    mode_next      = hcbd_pkg::MODE_DONE;
                    out_valid_next = 1'b1;
                    out_kind_next  = hcbd_pkg::KIND_ERROR;
                end
                else if (cur_count == '0)
                begin
                    mode_next      = hcbd_pkg::MODE_DONE;
                    out_valid_next = 1'b1;
                    out_kind_next  = hcbd_pkg::KIND_END;
                end
                else
                    mode_next = hcbd_pkg::MODE_PAYLOAD;
            end
            hcbd_pkg::MODE_PAYLOAD:
            begin
                count_next     = cur_count - hcbd_pkg::COUNT_ONE;
                out_valid_next = 1'b1;
                out_byte_next  = in_byte_reg;
                out_kind_next  = hcbd_pkg::KIND_DATA;
                if (cur_count == hcbd_pkg::COUNT_ONE)
                begin
                    mode_next = hcbd_pkg::MODE_SKIP;
                    skip_next = hcbd_pkg::SKIP_BYTES;
                end
            end
            hcbd_pkg::MODE_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 2'd0)
                begin
                    mode_next       = hcbd_pkg::MODE_DIGITS;
                    count_next      = '0;
                    digit_seen_next = 1'b0;
                end
            end
            default:
                mode_next = hcbd_pkg::MODE_DONE;
        endcase
    end

    // Parser state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= hcbd_pkg::MODE_DIGITS;
            count_reg      <= '0;
            digit_seen_reg <= 1'b0;
            skip_reg       <= '0;
        end
        else if (advance)
        begin
            mode_reg       <= mode_next;
            count_reg      <= count_next;
            digit_seen_reg <= digit_seen_next;
            skip_reg       <= skip_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= out_valid_next;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && out_valid_next)
        begin
            out_byte_reg <= out_byte_next;
            out_kind_reg <= out_kind_next;
        end
    end

endmodule

/* hdl/hcbd_checker.sv */
module hcbd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic [0:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser
);

    // A stalled result stays on the bus.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Only the three defined kinds appear.
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == hcbd_pkg::KIND_DATA || m_tuser == hcbd_pkg::KIND_END
                      || m_tuser == hcbd_pkg::KIND_ERROR))
        else $error("undefined result kind");

    // End and error results carry a zero byte.
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != hcbd_pkg::KIND_DATA |-> m_tdata == 8'd0)
        else $error("status result with nonzero byte");

    // With the output register empty, the input side is always open.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind http_chunked_body_decoder_top hcbd_checker u_hcbd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
